// ----- hw/rtl/dtcs_pkg.sv -----
// Shared types and constants for the decimal token checked summer.
// No dependencies.
`default_nettype none

package dtcs_pkg;

    localparam logic [7:0]  CH_MINUS = 8'd45;
    localparam logic [7:0]  CH_ZERO  = 8'd48;
    localparam logic [7:0]  CH_NINE  = 8'd57;
    localparam int          MAG_W    = 63;
    localparam int          VAL_W    = 64;

    typedef enum logic [1:0] {
        ST_REJECT  = 2'd0,
        ST_ADDED   = 2'd1,
        ST_SKIPPED = 2'd2,
        ST_TERM    = 2'd3
    } t_status;

    // Finished token handed from the parser to the summing stage
    typedef struct packed {
        logic             bad;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_tok;

endpackage

`default_nettype wire

// ----- hw/rtl/dtcs_tok.sv -----
// Token parser: per-character sign, digit and magnitude tracking.
// Holds one finished token for the summing stage. Uses dtcs_pkg.
`default_nettype none

module dtcs_tok
    import dtcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_token_last,
    input  wire logic       i_sum_ready,
    output logic            o_tok_valid,
    output t_tok            o_tok
);

    logic             r_at_start;
    logic             r_neg;
    logic             r_bad;
    logic [MAG_W-1:0] r_mag;
    logic             r_tok_valid;
    t_tok             r_tok;

    logic             w_minus;
    logic             w_digit;
    logic [MAG_W+3:0] w_prod;
    logic             w_ovf;
    logic             n_neg;
    logic             n_bad;
    logic [MAG_W-1:0] n_mag;

    always_comb begin
        w_minus = r_at_start && (i_char_code == CH_MINUS);
        w_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_prod  = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                + {{MAG_W{1'b0}}, i_char_code[3:0]};
        // magnitude above the signed 64-bit maximum
        w_ovf   = |w_prod[MAG_W+3:MAG_W];
        n_neg   = r_neg | w_minus;
        n_bad   = r_bad | (!w_minus && !w_digit) || (!w_minus && w_digit && w_ovf);
        n_mag   = r_mag;
        if (!w_minus && w_digit && !r_bad && !w_ovf) begin
            n_mag = w_prod[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_mag       <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            if (r_tok_valid && i_sum_ready) begin
                r_tok_valid <= 1'b0;
            end
            if (i_take) begin
                if (i_token_last) begin
                    r_at_start  <= 1'b1;
                    r_neg       <= 1'b0;
                    r_bad       <= 1'b0;
                    r_mag       <= '0;
                    r_tok_valid <= 1'b1;
                end else begin
                    r_at_start <= 1'b0;
                    r_neg      <= n_neg;
                    r_bad      <= n_bad;
                    r_mag      <= n_mag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_token_last) begin
            r_tok.bad <= n_bad;
            r_tok.neg <= n_neg;
            r_tok.mag <= n_mag;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

`default_nettype wire

// ----- hw/rtl/dtcs_sum.sv -----
// Summing stage: signs the token, checks the 64-bit sum, keeps the total
// and holds the result register. Uses dtcs_pkg.
`default_nettype none

module dtcs_sum
    import dtcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tok_valid,
    input  wire t_tok              i_tok,
    output logic                   o_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic signed [VAL_W-1:0] o_token_value,
    output logic signed [VAL_W-1:0] o_running_total
);

    logic                    r_out_valid;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] r_shown;
    logic signed [VAL_W-1:0] r_total;

    logic                    w_load;
    logic signed [VAL_W-1:0] w_x;
    logic        [VAL_W:0]   w_sum;
    logic                    w_sum_ovf;
    t_status                 n_status;
    logic signed [VAL_W-1:0] n_value;
    logic signed [VAL_W-1:0] n_total;
    logic signed [VAL_W-1:0] n_shown;

    assign o_ready = !r_out_valid || !i_out_stall;
    assign w_load  = i_tok_valid && o_ready;

    always_comb begin
        w_x       = i_tok.neg ? -$signed({1'b0, i_tok.mag}) : $signed({1'b0, i_tok.mag});
        w_sum     = {w_x[VAL_W-1], w_x} + {r_total[VAL_W-1], r_total};
        w_sum_ovf = w_sum[VAL_W] ^ w_sum[VAL_W-1];
        n_total   = r_total;
        n_shown   = r_total;
        n_value   = w_x;
        if (i_tok.bad) begin
            n_status = ST_REJECT;
            n_value  = '0;
        end else if (i_tok.mag == '0) begin
            n_status = ST_TERM;
            n_total  = '0;
        end else if (w_sum_ovf) begin
            n_status = ST_SKIPPED;
        end else begin
            n_status = ST_ADDED;
            n_total  = $signed(w_sum[VAL_W-1:0]);
            n_shown  = $signed(w_sum[VAL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_shown  <= n_shown;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_token_value   = r_value;
    assign o_running_total = r_shown;

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_token_checked_summer.sv -----
// Top level of the decimal token checked summer: parser and summing stage.
// Uses dtcs_pkg, dtcs_tok and dtcs_sum.
//
// Takes one ASCII character per cycle; a token ends on the transfer with
// i_token_last high and yields exactly one result through the parser
// register, then the result register. A token may begin with '-', all
// other characters must be digits; magnitudes above 2^63-1 or non-digits
// give status 0. Otherwise the signed value is added to the running total
// (status 1), skipped if the 64-bit sum would overflow (status 2), or, for
// a zero value, the total is reported and cleared (status 3). Sustained
// rate is one character per cycle; o_in_stall rises only while a finished
// token waits behind a stalled result register.
`default_nettype none

module decimal_token_checked_summer
    import dtcs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_char_code,
    input  wire logic               i_token_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic signed [VAL_W-1:0] o_token_value,
    output logic signed [VAL_W-1:0] o_running_total
);

    logic w_take;
    logic w_tok_valid;
    t_tok w_tok;
    logic w_sum_ready;

    assign o_in_stall = w_tok_valid && !w_sum_ready;
    assign w_take     = i_in_valid && !o_in_stall;

    dtcs_tok u_tok (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_char_code  (i_char_code),
        .i_token_last (i_token_last),
        .i_sum_ready  (w_sum_ready),
        .o_tok_valid  (w_tok_valid),
        .o_tok        (w_tok)
    );

    dtcs_sum u_sum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (w_tok_valid),
        .i_tok           (w_tok),
        .o_ready         (w_sum_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_token_value   (o_token_value),
        .o_running_total (o_running_total)
    );

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_REJECT) |-> o_token_value == '0)
        else $error("rejected token carries a value");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_TERM) |-> o_token_value == '0)
        else $error("terminator carries a nonzero value");

    a_added_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_ADDED) |-> o_token_value != '0)
        else $error("zero token reported as added");

    a_tok_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_valid && !w_sum_ready |=> w_tok_valid && $stable(w_tok))
        else $error("pending token lost while result stalled");

endmodule

`default_nettype wire
